### hdl/vau_pkg.sv
package vau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int OPCODE_BITS   = 4;

    localparam int SQRT_STEPS_PER_STAGE = 2;
    localparam int DIV_STEPS_PER_STAGE  = 2;

    localparam logic [OPCODE_BITS-1:0] OP_ADD       = 4'd0;
    localparam logic [OPCODE_BITS-1:0] OP_SUB       = 4'd1;
    localparam logic [OPCODE_BITS-1:0] OP_NEGATE    = 4'd2;
    localparam logic [OPCODE_BITS-1:0] OP_SCALE     = 4'd3;
    localparam logic [OPCODE_BITS-1:0] OP_MUL       = 4'd4;
    localparam logic [OPCODE_BITS-1:0] OP_DIV       = 4'd5;
    localparam logic [OPCODE_BITS-1:0] OP_DOT       = 4'd6;
    localparam logic [OPCODE_BITS-1:0] OP_CROSS     = 4'd7;
    localparam logic [OPCODE_BITS-1:0] OP_LENGTH    = 4'd8;
    localparam logic [OPCODE_BITS-1:0] OP_NORMALIZE = 4'd9;
    localparam logic [OPCODE_BITS-1:0] OP_EQUAL     = 4'd10;

endpackage

### hdl/vau_sqrt_pipe.sv
module vau_sqrt_pipe #(
    parameter int W = 32
) (
    input  logic           clk,
    input  logic           en,
    input  logic [2*W-1:0] rad,
    output logic [W-1:0]   root
);
    import vau_pkg::*;

    localparam int STAGES = (W + SQRT_STEPS_PER_STAGE - 1) / SQRT_STEPS_PER_STAGE;

    typedef struct packed {
        logic [W:0]     rem;
        logic [W-1:0]   root;
        logic [2*W-1:0] rad;
    } sq_t;

    sq_t st_reg [STAGES];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        sq_t st_in;
        sq_t st_next;

        if (g == 0)
        begin : g_first
            assign st_in = '{rem: '0, root: '0, rad: rad};
        end
        else
        begin : g_rest
            assign st_in = st_reg[g-1];
        end

        always_comb
        begin
            logic [W+2:0] trial_rem;
            logic [W+2:0] trial;
            logic [W+2:0] diff;
            st_next = st_in;
            for (int k = 0; k < SQRT_STEPS_PER_STAGE; k++)
            begin
                if (g * SQRT_STEPS_PER_STAGE + k < W)
                begin
                    trial_rem   = {st_next.rem, st_next.rad[2*W-1 -: 2]};
                    trial       = {1'b0, st_next.root, 2'b01};
                    diff        = trial_rem - trial;
                    st_next.rad = {st_next.rad[2*W-3:0], 2'b00};
                    if (trial_rem >= trial)
                    begin
                        st_next.rem  = diff[W:0];
                        st_next.root = {st_next.root[W-2:0], 1'b1};
                    end
                    else
                    begin
                        st_next.rem  = trial_rem[W:0];
                        st_next.root = {st_next.root[W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g] <= st_next;
            end
        end
    end

    assign root = st_reg[STAGES-1].root;

endmodule

### hdl/vau_div_pipe.sv
module vau_div_pipe #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic           clk,
    input  logic           en,
    input  logic [W+F-1:0] dividend,
    input  logic [W-1:0]   divisor,
    output logic [W+F-1:0] quotient
);
    import vau_pkg::*;

    localparam int DW     = W + F;
    localparam int STAGES = (DW + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

    // qd shifts the dividend out at the top and the quotient in at the bottom
    typedef struct packed {
        logic [W-1:0]  rem;
        logic [DW-1:0] qd;
        logic [W-1:0]  dsr;
    } dv_t;

    dv_t st_reg [STAGES];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        dv_t st_in;
        dv_t st_next;

        if (g == 0)
        begin : g_first
            assign st_in = '{rem: '0, qd: dividend, dsr: divisor};
        end
        else
        begin : g_rest
            assign st_in = st_reg[g-1];
        end

        always_comb
        begin
            logic [W:0] t;
            logic [W:0] diff;
            st_next = st_in;
            for (int k = 0; k < DIV_STEPS_PER_STAGE; k++)
            begin
                if (g * DIV_STEPS_PER_STAGE + k < DW)
                begin
                    t    = {st_next.rem, st_next.qd[DW-1]};
                    diff = t - {1'b0, st_next.dsr};
                    if (t >= {1'b0, st_next.dsr})
                    begin
                        st_next.rem = diff[W-1:0];
                        st_next.qd  = {st_next.qd[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        st_next.rem = t[W-1:0];
                        st_next.qd  = {st_next.qd[DW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g] <= st_next;
            end
        end
    end

    assign quotient = st_reg[STAGES-1].qd;

endmodule

### hdl/vector3_arithmetic_unit.sv
// Three-component vector unit, signed fixed point (Q16.16 by default).
// Input channel s_*: one transaction per operation. s_tuser carries the
// opcode, s_tdata the vectors a, b and the scalar. Output channel m_*:
// one transaction per input, in input order, with the result vector, the
// scalar result and the equal / divide-by-zero / saturated flags.
// The latency is the same for every opcode. The depth is set by the
// square root pipeline (two root bits per stage) followed by the
// divider pipeline (two quotient bits per stage) used by divide and
// normalize.
// Throughput: one transaction per cycle while m_tready is high.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits; the first input can be taken right after
// rst_n is released.
module vector3_arithmetic_unit #(
    parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = vau_pkg::WORD_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
    input  logic [((7*WORD_BITS+7)/8)*8-1:0]          s_tdata,
    // opcode
    input  logic [vau_pkg::OPCODE_BITS-1:0]           s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // r_x, r_y, r_z, scalar_out, is_equal, div_zero, saturated
    output logic [((4*WORD_BITS+3+7)/8)*8-1:0]        m_tdata
);
    import vau_pkg::*;

    localparam int W        = WORD_BITS;
    localparam int F        = FRAC_BITS;
    localparam int DW       = W + F;
    localparam int PW       = 2 * W;
    localparam int CW       = (2 * W + 2 > DW + 2) ? 2 * W + 2 : DW + 2;
    localparam int OUT_BITS = 4 * W + 3;
    localparam int OUT_PAD  = ((OUT_BITS + 7) / 8) * 8;
    localparam int SQ_ST    = (W + SQRT_STEPS_PER_STAGE - 1) / SQRT_STEPS_PER_STAGE;
    localparam int DIV_ST   = (DW + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

    localparam logic signed [CW-1:0] CMAX = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {{(CW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [W-1:0] WMAX_V = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN_V = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [OPCODE_BITS-1:0] op;
        logic                   eq;
        logic [2:0][W-1:0]      r;
        logic [W-1:0]           sc;
        logic                   sat;
        logic [2:0][W-1:0]      a;
        logic [W-1:0]           s;
    } fsb_t;

    typedef struct packed {
        logic              eq;
        logic [2:0][W-1:0] r;
        logic [W-1:0]      sc;
        logic              sat;
        logic              dz;
        logic [2:0]        qneg;
        logic              use_q;
    } bsb_t;

    // {clipped flag, value}
    function automatic logic [W:0] clip_fn(input logic signed [CW-1:0] v);
        if (v > CMAX)
            return {1'b1, CMAX[W-1:0]};
        else if (v < CMIN)
            return {1'b1, CMIN[W-1:0]};
        else
            return {1'b0, v[W-1:0]};
    endfunction

    logic en;

    // ---------------- stage 1: operand select and multiply ----------------
    logic [OPCODE_BITS-1:0] op_in;
    logic signed [W-1:0]    a_in [3];
    logic signed [W-1:0]    b_in [3];
    logic signed [W-1:0]    s_in;
    logic signed [W-1:0]    x1 [3];
    logic signed [W-1:0]    y1 [3];
    logic signed [W-1:0]    x2 [3];
    logic signed [W-1:0]    y2 [3];
    logic signed [W:0]      as_next [3];

    logic                   v1_reg;
    logic [OPCODE_BITS-1:0] op1_reg;
    logic                   eq1_reg;
    logic signed [PW-1:0]   p1_reg [3];
    logic signed [PW-1:0]   p2_reg [3];
    logic signed [W:0]      as1_reg [3];
    logic [2:0][W-1:0]      a1_reg;
    logic [W-1:0]           s1_reg;

    assign op_in = s_tuser;
    assign s_in  = s_tdata[6*W +: W];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_in[i] = s_tdata[i*W +: W];
            b_in[i] = s_tdata[(3+i)*W +: W];
        end
        for (int i = 0; i < 3; i++)
        begin
            x1[i] = a_in[i];
            y1[i] = b_in[i];
            x2[i] = '0;
            y2[i] = '0;
        end
        case (op_in) inside
            OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                    y1[i] = s_in;
            end
            OP_LENGTH, OP_NORMALIZE:
            begin
                for (int i = 0; i < 3; i++)
                    y1[i] = a_in[i];
            end
            OP_CROSS:
            begin
                x1[0] = a_in[1]; y1[0] = b_in[2]; x2[0] = a_in[2]; y2[0] = b_in[1];
                x1[1] = a_in[2]; y1[1] = b_in[0]; x2[1] = a_in[0]; y2[1] = b_in[2];
                x1[2] = a_in[0]; y1[2] = b_in[1]; x2[2] = a_in[1]; y2[2] = b_in[0];
            end
            default: ;
        endcase
        for (int i = 0; i < 3; i++)
        begin
            case (op_in) inside
                OP_ADD:    as_next[i] = {a_in[i][W-1], a_in[i]} + {b_in[i][W-1], b_in[i]};
                OP_SUB:    as_next[i] = {a_in[i][W-1], a_in[i]} - {b_in[i][W-1], b_in[i]};
                OP_NEGATE: as_next[i] = -{a_in[i][W-1], a_in[i]};
                default:   as_next[i] = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg <= op_in;
            eq1_reg <= (a_in[0] == b_in[0]) && (a_in[1] == b_in[1]) && (a_in[2] == b_in[2]);
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i]  <= x1[i] * y1[i];
                p2_reg[i]  <= x2[i] * y2[i];
                as1_reg[i] <= as_next[i];
                a1_reg[i]  <= a_in[i];
            end
            s1_reg <= s_in;
        end
    end

    // ---------------- stage 2: shift, sum and clip ----------------
    logic signed [CW-1:0] t_w [3];
    logic signed [CW-1:0] as_w [3];
    logic signed [CW-1:0] dot_w;
    logic [W:0]           c_t [3];
    logic [W:0]           c_as [3];
    logic [W:0]           c_dot;
    logic [PW-1:0]        rad_next;
    fsb_t                 sb2_next;

    logic                 v2_reg;
    fsb_t                 sb2_reg;
    logic [PW-1:0]        rad2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_w[i]  = (CW'(p1_reg[i]) - CW'(p2_reg[i])) >>> F;
            as_w[i] = CW'(as1_reg[i]);
            c_t[i]  = clip_fn(t_w[i]);
            c_as[i] = clip_fn(as_w[i]);
        end
        dot_w    = (CW'(p1_reg[0]) + CW'(p1_reg[1]) + CW'(p1_reg[2])) >>> F;
        c_dot    = clip_fn(dot_w);
        rad_next = $unsigned(p1_reg[0]) + $unsigned(p1_reg[1]) + $unsigned(p1_reg[2]);

        sb2_next.op  = op1_reg;
        sb2_next.eq  = eq1_reg;
        sb2_next.r   = '0;
        sb2_next.sc  = '0;
        sb2_next.sat = 1'b0;
        sb2_next.a   = a1_reg;
        sb2_next.s   = s1_reg;
        case (op1_reg) inside
            OP_ADD, OP_SUB, OP_NEGATE:
            begin
                for (int i = 0; i < 3; i++)
                    sb2_next.r[i] = c_as[i][W-1:0];
                sb2_next.sat = c_as[0][W] | c_as[1][W] | c_as[2][W];
            end
            OP_SCALE, OP_MUL, OP_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                    sb2_next.r[i] = c_t[i][W-1:0];
                sb2_next.sat = c_t[0][W] | c_t[1][W] | c_t[2][W];
            end
            OP_DOT:
            begin
                sb2_next.sc  = c_dot[W-1:0];
                sb2_next.sat = c_dot[W];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb2_reg  <= sb2_next;
            rad2_reg <= rad_next;
        end
    end

    // ---------------- square root ----------------
    logic [W-1:0]      root;
    logic [SQ_ST-1:0]  fval_reg;
    fsb_t              fsb_reg [SQ_ST];

    vau_sqrt_pipe #(
        .W (W)
    ) u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (rad2_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fsb_reg[0] <= sb2_reg;
            for (int k = 1; k < SQ_ST; k++)
                fsb_reg[k] <= fsb_reg[k-1];
        end
    end

    // ---------------- divider entry ----------------
    fsb_t          fe;
    logic [W-1:0]  s_mag;
    logic [W-1:0]  dsr_raw;
    logic [W-1:0]  dsr;
    logic [W-1:0]  a_mag [3];
    logic [DW-1:0] dvd [3];
    logic          s_zero;
    logic [W:0]    c_len;
    bsb_t          be_next;

    assign fe = fsb_reg[SQ_ST-1];

    always_comb
    begin
        s_zero  = (fe.s == '0);
        s_mag   = fe.s[W-1] ? (~fe.s + W'(1)) : fe.s;
        dsr_raw = (fe.op == OP_DIV) ? s_mag : root;
        dsr     = (dsr_raw == '0) ? W'(1) : dsr_raw;
        c_len   = clip_fn({{(CW-W){1'b0}}, root});
        for (int i = 0; i < 3; i++)
        begin
            a_mag[i] = fe.a[i][W-1] ? (~fe.a[i] + W'(1)) : fe.a[i];
            dvd[i]   = {a_mag[i], {F{1'b0}}};
        end

        be_next.eq    = fe.eq;
        be_next.r     = fe.r;
        be_next.sc    = fe.sc;
        be_next.sat   = fe.sat;
        be_next.dz    = 1'b0;
        be_next.use_q = 1'b0;
        for (int i = 0; i < 3; i++)
            be_next.qneg[i] = fe.a[i][W-1] ^ ((fe.op == OP_DIV) & fe.s[W-1]);
        case (fe.op) inside
            OP_DIV:
            begin
                if (s_zero)
                begin
                    be_next.dz = 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (fe.a[i][W-1])
                            be_next.r[i] = WMIN_V;
                        else if (fe.a[i] != '0)
                            be_next.r[i] = WMAX_V;
                        else
                            be_next.r[i] = '0;
                    end
                    be_next.sat = (fe.a[0] != '0) | (fe.a[1] != '0) | (fe.a[2] != '0);
                end
                else
                begin
                    be_next.use_q = 1'b1;
                end
            end
            OP_NORMALIZE:
            begin
                be_next.use_q = 1'b1;
            end
            OP_LENGTH:
            begin
                be_next.sc  = c_len[W-1:0];
                be_next.sat = c_len[W];
            end
            OP_EQUAL: ;
            default: ;
        endcase
    end

    // ---------------- divider ----------------
    logic [DW-1:0]     quo [3];
    logic [DIV_ST-1:0] bval_reg;
    bsb_t              bsb_reg [DIV_ST];

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        vau_div_pipe #(
            .W (W),
            .F (F)
        ) u_div (
            .clk      (clk),
            .en       (en),
            .dividend (dvd[i]),
            .divisor  (dsr),
            .quotient (quo[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bsb_reg[0] <= be_next;
            for (int k = 1; k < DIV_ST; k++)
                bsb_reg[k] <= bsb_reg[k-1];
        end
    end

    // ---------------- output stage ----------------
    bsb_t                 bo;
    logic signed [CW-1:0] qs [3];
    logic [W:0]           c_q [3];
    logic [OUT_BITS-1:0]  out_next;
    logic [2:0][W-1:0]    r_fin;
    logic                 sat_fin;

    logic                 out_valid_reg;
    logic [OUT_BITS-1:0]  out_data_reg;

    assign bo = bsb_reg[DIV_ST-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qs[i] = {{(CW-DW){1'b0}}, quo[i]};
            if (bo.qneg[i])
                qs[i] = -qs[i];
            c_q[i]   = clip_fn(qs[i]);
            r_fin[i] = bo.use_q ? c_q[i][W-1:0] : bo.r[i];
        end
        sat_fin  = bo.sat | (bo.use_q & (c_q[0][W] | c_q[1][W] | c_q[2][W]));
        out_next = {sat_fin, bo.dz, bo.eq, bo.sc, r_fin[2], r_fin[1], r_fin[0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_next;
        end
    end

    // ---------------- valid bits and flow control ----------------
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_PAD-OUT_BITS){1'b0}}, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            fval_reg      <= '0;
            bval_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= s_tvalid;
            v2_reg        <= v1_reg;
            fval_reg      <= {fval_reg[SQ_ST-2:0], v2_reg};
            bval_reg      <= {bval_reg[DIV_ST-2:0], fval_reg[SQ_ST-1]};
            out_valid_reg <= bval_reg[DIV_ST-1];
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted transaction did not enter stage 1");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v2_reg) && $stable(fval_reg) && $stable(bval_reg))
        else $error("pipeline moved during stall");

    a_dz_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_data_reg[4*W+1] |-> out_data_reg[4*W-1:3*W] == '0)
        else $error("divide by zero with nonzero scalar result");

    a_dz_rx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_data_reg[4*W+1] |->
            (out_data_reg[W-1:0] == WMAX_V) || (out_data_reg[W-1:0] == WMIN_V) ||
            (out_data_reg[W-1:0] == '0))
        else $error("divide by zero result not saturated or zero");
`endif

endmodule

### test/tb_vector3_arithmetic_unit.sv
`timescale 1ns / 100ps

module tb_vector3_arithmetic_unit;
    import vau_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int WB = WORD_BITS_DEF;
    localparam int IN_W = ((7*WB+7)/8)*8;
    localparam int OUT_W = ((4*WB+3+7)/8)*8;
    localparam int LATENCY = 43;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic signed [63:0] WMAX = 64'sd2147483647;
    localparam logic signed [63:0] WMIN = -64'sd2147483648;

    typedef struct packed {
        logic [3:0] op;
        logic signed [31:0] ax, ay, az, bx, by, bz, s;
    } vec_op_t;

    typedef struct packed {
        logic signed [31:0] rx, ry, rz, sc;
        logic eq, dz, sat;
    } vec_res_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;   // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
    logic [3:0] s_tuser;        // opcode
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;  // r_x, r_y, r_z, scalar_out, is_equal, div_zero, saturated

    int src_idle_pct;
    int snk_idle_pct;
    bit hold_off;
    longint cycles;

    vector3_arithmetic_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic logic signed [63:0] floor_shr(logic signed [127:0] x);
        logic signed [127:0] t;
        t = x >>> FB;
        return t[63:0];
    endfunction

    function automatic logic signed [63:0] clamp(logic signed [63:0] v, ref logic sat);
        if (v > WMAX)
        begin
            sat = 1'b1;
            return WMAX;
        end
        if (v < WMIN)
        begin
            sat = 1'b1;
            return WMIN;
        end
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [127:0] n);
        logic [63:0] r;
        r = 0;
        for (int i = 63; i >= 0; i--)
        begin
            logic [127:0] c;
            c = {64'd0, r | (64'd1 << i)};
            if (c * c <= n)
                r = r | (64'd1 << i);
        end
        return r;
    endfunction

    function automatic vec_res_t vector_result(vec_op_t t);
        logic signed [63:0] a[3];
        logic signed [63:0] b[3];
        logic signed [63:0] r[3];
        logic signed [63:0] sc;
        logic signed [63:0] s;
        logic signed [127:0] acc;
        logic [127:0] sq;
        logic [63:0] len;
        logic sat;
        logic dz;
        vec_res_t o;
        a[0] = 64'(t.ax); a[1] = 64'(t.ay); a[2] = 64'(t.az);
        b[0] = 64'(t.bx); b[1] = 64'(t.by); b[2] = 64'(t.bz);
        s = 64'(t.s);
        r[0] = 0; r[1] = 0; r[2] = 0;
        sc = 0; sat = 0; dz = 0;
        case (t.op)
            OP_ADD:    for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
            OP_SUB:    for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
            OP_NEGATE: for (int i = 0; i < 3; i++) r[i] = -a[i];
            OP_SCALE:  for (int i = 0; i < 3; i++) r[i] = floor_shr(128'(a[i] * s));
            OP_MUL:    for (int i = 0; i < 3; i++) r[i] = floor_shr(128'(a[i] * b[i]));
            OP_DIV:
                if (s == 0)
                begin
                    dz = 1;
                    for (int i = 0; i < 3; i++)
                        if (a[i] > 0)
                        begin
                            r[i] = WMAX;
                            sat = 1;
                        end
                        else if (a[i] < 0)
                        begin
                            r[i] = WMIN;
                            sat = 1;
                        end
                end
                else
                    for (int i = 0; i < 3; i++) r[i] = (a[i] <<< FB) / s;
            OP_DOT:
            begin
                acc = 0;
                for (int i = 0; i < 3; i++) acc += 128'(a[i]) * 128'(b[i]);
                sc = floor_shr(acc);
            end
            OP_CROSS:
            begin
                r[0] = floor_shr(128'(a[1]) * 128'(b[2]) - 128'(a[2]) * 128'(b[1]));
                r[1] = floor_shr(128'(a[2]) * 128'(b[0]) - 128'(a[0]) * 128'(b[2]));
                r[2] = floor_shr(128'(a[0]) * 128'(b[1]) - 128'(a[1]) * 128'(b[0]));
            end
            OP_LENGTH, OP_NORMALIZE:
            begin
                sq = 0;
                for (int i = 0; i < 3; i++) sq += 128'(a[i] * a[i]);
                len = int_sqrt(sq);
                if (t.op == OP_LENGTH)
                    sc = len;
                else
                    for (int i = 0; i < 3; i++)
                        r[i] = (len != 0) ? (a[i] <<< FB) / $signed(len) : a[i];
            end
            default: ;
        endcase
        o.rx = 32'(clamp(r[0], sat));
        o.ry = 32'(clamp(r[1], sat));
        o.rz = 32'(clamp(r[2], sat));
        o.sc = 32'(clamp(sc, sat));
        o.eq = (t.ax == t.bx) && (t.ay == t.by) && (t.az == t.bz);
        o.dz = dz;
        o.sat = sat;
        return o;
    endfunction

    class vector_scoreboard;
        vec_res_t pending[$];
        int errors;

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
            errors++;
        endtask

        function void note_input(vec_op_t t);
            pending.push_back(vector_result(t));
        endfunction

        task check_result(logic [OUT_W-1:0] d);
            vec_res_t w;
            if (pending.size() == 0)
            begin
                report("unexpected transaction", d[31:0], 32'd0);
                return;
            end
            w = pending.pop_front();
            if (d[31:0] !== w.rx) report("r_x", d[31:0], w.rx);
            if (d[63:32] !== w.ry) report("r_y", d[63:32], w.ry);
            if (d[95:64] !== w.rz) report("r_z", d[95:64], w.rz);
            if (d[127:96] !== w.sc) report("scalar_out", d[127:96], w.sc);
            if (d[128] !== w.eq) report("is_equal", 32'(d[128]), 32'(w.eq));
            if (d[129] !== w.dz) report("div_zero", 32'(d[129]), 32'(w.dz));
            if (d[130] !== w.sat) report("saturated", 32'(d[130]), 32'(w.sat));
        endtask
    endclass

    vector_scoreboard sb;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 0;
            3: return $urandom_range(0, 8) << 16;
            4: return -($urandom_range(0, 8) << 16);
            5: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_op(vec_op_t t);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= t.op;
        s_tdata <= {t.s, t.bz, t.by, t.bx, t.az, t.ay, t.ax};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(t);
    endtask

    task automatic send_random(int n, bit any_op);
        vec_op_t t;
        for (int i = 0; i < n; i++)
        begin
            t.op = any_op ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 10));
            t.ax = rand_word(); t.ay = rand_word(); t.az = rand_word();
            if ($urandom_range(0, 9) == 0)
                {t.bx, t.by, t.bz} = {t.ax, t.ay, t.az};
            else
            begin
                t.bx = rand_word(); t.by = rand_word(); t.bz = rand_word();
            end
            t.s = rand_word();
            send_op(t);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles++;
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            m_tready <= !hold_off && ($urandom_range(0, 99) >= snk_idle_pct);
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        vec_op_t t;
        sb = new();
        cycles = 0;
        hold_off = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        m_tready = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: every opcode with extremes, zero divisor, zero vector
        for (int op = 0; op < 16; op++)
        begin
            t.op = 4'(op);
            t.ax = 32'h7fffffff; t.ay = 32'h80000000; t.az = 0;
            t.bx = 32'h80000000; t.by = 32'h7fffffff; t.bz = 32'h00010000;
            t.s = (op == OP_DIV) ? 0 : 32'h80000000;
            send_op(t);
        end
        t = '0;
        t.op = OP_NORMALIZE;
        send_op(t);
        t.op = OP_DIV;
        send_op(t);
        t.op = OP_EQUAL;
        send_op(t);
        t.op = OP_NORMALIZE;
        t.ax = 32'h00030000; t.ay = 32'hfffc0000; t.az = 1;
        send_op(t);
        t.op = OP_DIV; t.s = 32'hffffffff;
        send_op(t);
        t.op = OP_LENGTH; t.ax = 32'h80000000; t.ay = 32'h80000000; t.az = 32'h80000000;
        send_op(t);

        src_idle_pct = 8;
        snk_idle_pct = 50;
        send_random(600, 1);

        // long receiver hold-off while the sender keeps offering
        src_idle_pct = 0;
        snk_idle_pct = 0;
        fork
            begin
                hold_off = 1;
                repeat (150) @(posedge clk);
                hold_off = 0;
            end
            send_random(100, 0);
        join

        src_idle_pct = 50;
        snk_idle_pct = 8;
        send_random(600, 1);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_random(700, 1);
        s_tvalid <= 0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
